// ===== rtl/core/efra_pkg.sv =====
// ============================================================================
// efra_pkg
// Shared widths, constants and the room entry type of the allocator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package efra_pkg;

    localparam int IN_W   = 32;
    localparam int TIME_W = 40;
    localparam int CNT_W  = 32;
    localparam int ROOM_W = 4;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] ROOMS_RESET = 5'd16;

    typedef struct packed {
        logic [TIME_W-1:0] busy;
        logic [CNT_W-1:0]  count;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/efra_room_mem.sv =====
// ============================================================================
// efra_room_mem
// Room table: busy-until time and use count per room, one read and one write
// port, registered read data. Per-entry valid bits make an unwritten or
// cleared entry read as zero.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module efra_room_mem #(
    parameter int NUM_ROOMS = 16,
    parameter int IW        = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            clear,
    input  wire logic [IW-1:0]   rd_addr,
    output wire efra_pkg::entry_t rd_data,
    input  wire logic            wr_en,
    input  wire logic [IW-1:0]   wr_addr,
    input  wire efra_pkg::entry_t wr_data
);
    import efra_pkg::*;

    entry_t               mem [NUM_ROOMS];
    entry_t               rd_data_reg;
    logic [NUM_ROOMS-1:0] valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/earliest_free_resource_allocator.sv =====
// ============================================================================
// earliest_free_resource_allocator
// Books each request on the lowest free room, or delays it on the room that
// frees earliest, and reports the running busiest room.
// ============================================================================
//  channel  | ports              | direction | handshake
//  request  | s_start_time ...   | in        | s_valid / s_ready
//  result   | m_room ...         | out       | m_valid / m_ready
//  config   | cfg_wr_data        | in        | cfg_wr_en, no wait
//
//  Each item scans all N active rooms, N the active room count:
//  the room table has one read port, so the scan reads one entry a cycle.
//  Reset and restart clear the table through per-room valid bits.
//  A result waits in the output register; a new item is taken meanwhile, and
//  the write-back stalls only if the previous result is still not taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module earliest_free_resource_allocator #(
    parameter int NUM_ROOMS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [efra_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                          s_valid,
    output wire logic                          s_ready,
    input  wire logic [efra_pkg::IN_W-1:0]     s_start_time,
    input  wire logic [efra_pkg::IN_W-1:0]     s_end_time,
    input  wire logic                          s_restart,
    output wire logic                          m_valid,
    input  wire logic                          m_ready,
    output wire logic [efra_pkg::ROOM_W-1:0]   m_room,
    output wire logic [efra_pkg::TIME_W-1:0]   m_begin_time,
    output wire logic [efra_pkg::TIME_W-1:0]   m_finish_time,
    output wire logic                          m_delayed,
    output wire logic [efra_pkg::ROOM_W-1:0]   m_busiest_room,
    output wire logic [efra_pkg::CNT_W-1:0]    m_busiest_count
);
    import efra_pkg::*;

    localparam int IW = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
    localparam int CW = $clog2(NUM_ROOMS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]        state_reg;
    logic [CFG_W-1:0]  rooms_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     n_next;
    logic [CW-1:0]     iss_reg;
    logic              ev_valid_reg;
    logic [IW-1:0]     ev_idx_reg;
    logic              ev_last;

    logic [IN_W-1:0]   start_reg;
    logic [IN_W-1:0]   dur_reg;
    logic              found_reg;
    logic [IW-1:0]     pick_reg;
    logic [CNT_W-1:0]  pick_cnt_reg;
    logic [IW-1:0]     early_reg;
    logic [TIME_W-1:0] ebusy_reg;
    logic [CNT_W-1:0]  ecnt_reg;

    logic [IW-1:0]     sel_reg;
    logic [TIME_W-1:0] begin_reg;
    logic [TIME_W-1:0] finish_reg;
    logic              delayed_reg;
    logic [CNT_W-1:0]  cnt_new_reg;

    logic [IW-1:0]     best_room_reg;
    logic [CNT_W-1:0]  best_cnt_reg;
    logic [IW-1:0]     best_room_next;
    logic [CNT_W-1:0]  best_cnt_next;

    logic              out_valid_reg;
    logic [ROOM_W-1:0] out_room_reg;
    logic [TIME_W-1:0] out_begin_reg;
    logic [TIME_W-1:0] out_finish_reg;
    logic              out_delayed_reg;
    logic [ROOM_W-1:0] out_best_room_reg;
    logic [CNT_W-1:0]  out_best_cnt_reg;

    logic              in_acc;
    logic              out_free;
    logic              do_write;
    entry_t            rd_entry;
    entry_t            wr_entry;
    logic              ev_free;
    logic              ev_earlier;

    logic [TIME_W-1:0] begin_next;
    logic [TIME_W:0]   sum_next;
    logic [CNT_W-1:0]  cnt_sel;

    assign in_acc   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_ready;
    assign do_write = (state_reg == ST_WRITE) && out_free;

    always_comb begin
        if (rooms_reg == '0) begin
            n_next = CW'(1);
        end else if (int'(rooms_reg) > NUM_ROOMS) begin
            n_next = CW'(NUM_ROOMS);
        end else begin
            n_next = CW'(rooms_reg);
        end
    end

    assign wr_entry = '{busy: finish_reg, count: cnt_new_reg};

    efra_room_mem #(
        .NUM_ROOMS (NUM_ROOMS),
        .IW        (IW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (in_acc && s_restart),
        .rd_addr (iss_reg[IW-1:0]),
        .rd_data (rd_entry),
        .wr_en   (do_write),
        .wr_addr (sel_reg),
        .wr_data (wr_entry)
    );

    assign ev_last    = (CW'(ev_idx_reg) == n_reg - CW'(1));
    assign ev_free    = (rd_entry.busy <= TIME_W'(start_reg));
    assign ev_earlier = (ev_idx_reg == '0) || (rd_entry.busy < ebusy_reg);

    assign begin_next = found_reg ? TIME_W'(start_reg) : ebusy_reg;
    assign sum_next   = {1'b0, begin_next} + (TIME_W + 1)'(dur_reg);
    assign cnt_sel    = found_reg ? pick_cnt_reg : ecnt_reg;

    always_comb begin
        best_room_next = best_room_reg;
        best_cnt_next  = best_cnt_reg;
        if ((cnt_new_reg > best_cnt_reg) ||
            ((cnt_new_reg == best_cnt_reg) && (sel_reg < best_room_reg))) begin
            best_room_next = sel_reg;
            best_cnt_next  = cnt_new_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rooms_reg     <= ROOMS_RESET;
            iss_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            best_room_reg <= '0;
            best_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rooms_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            ev_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        iss_reg   <= '0;
                        found_reg <= 1'b0;
                        if (s_restart) begin
                            best_room_reg <= '0;
                            best_cnt_reg  <= '0;
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (iss_reg < n_reg) begin
                        ev_valid_reg <= 1'b1;
                        iss_reg      <= iss_reg + CW'(1);
                    end
                    if (ev_valid_reg && !found_reg && ev_free) begin
                        found_reg <= 1'b1;
                    end
                    if (ev_valid_reg && ev_last) begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (out_free) begin
                        best_room_reg <= best_room_next;
                        best_cnt_reg  <= best_cnt_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            n_reg     <= n_next;
            start_reg <= s_start_time;
            dur_reg   <= (s_end_time >= s_start_time) ? s_end_time - s_start_time : '0;
        end
        ev_idx_reg <= iss_reg[IW-1:0];
        if (state_reg == ST_SCAN && ev_valid_reg) begin
            if (!found_reg && ev_free) begin
                pick_reg     <= ev_idx_reg;
                pick_cnt_reg <= rd_entry.count;
            end
            if (ev_earlier) begin
                early_reg <= ev_idx_reg;
                ebusy_reg <= rd_entry.busy;
                ecnt_reg  <= rd_entry.count;
            end
        end
        if (state_reg == ST_CALC) begin
            sel_reg     <= found_reg ? pick_reg : early_reg;
            begin_reg   <= begin_next;
            finish_reg  <= sum_next[TIME_W] ? '1 : sum_next[TIME_W-1:0];
            delayed_reg <= !found_reg;
            cnt_new_reg <= (&cnt_sel) ? cnt_sel : cnt_sel + CNT_W'(1);
        end
        if (do_write) begin
            out_room_reg      <= ROOM_W'(sel_reg);
            out_begin_reg     <= begin_reg;
            out_finish_reg    <= finish_reg;
            out_delayed_reg   <= delayed_reg;
            out_best_room_reg <= ROOM_W'(best_room_next);
            out_best_cnt_reg  <= best_cnt_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_room          = out_room_reg;
    assign m_begin_time    = out_begin_reg;
    assign m_finish_time   = out_finish_reg;
    assign m_delayed       = out_delayed_reg;
    assign m_busiest_room  = out_best_room_reg;
    assign m_busiest_count = out_best_cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/efra_checker.sv =====
// ============================================================================
// efra_checker
// Port-level checks on the allocator's request and result channels.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module efra_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [efra_pkg::ROOM_W-1:0]   m_room,
    input  wire logic [efra_pkg::TIME_W-1:0]   m_begin_time,
    input  wire logic [efra_pkg::TIME_W-1:0]   m_finish_time,
    input  wire logic                          m_delayed,
    input  wire logic [efra_pkg::CNT_W-1:0]    m_busiest_count
);
    import efra_pkg::*;

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_room) && $stable(m_finish_time);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result item changed while stalled");

    property p_busy_after_accept;
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("request taken while previous item still in work");

    property p_finish_order;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_finish_time >= m_begin_time;
    endproperty
    a_finish_order: assert property (p_finish_order) else $error("finish before begin");

    property p_count_nonzero;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_busiest_count != '0;
    endproperty
    a_count_nonzero: assert property (p_count_nonzero) else $error("busiest count is zero");

    property p_on_time_begin;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_delayed |-> m_begin_time[TIME_W-1:IN_W] == '0;
    endproperty
    a_on_time_begin: assert property (p_on_time_begin)
        else $error("undelayed item begins beyond request range");

endmodule

bind earliest_free_resource_allocator efra_checker u_efra_checker (.*);

`default_nettype wire
